// ----- hw/rtl/cfse_pkg.sv -----
// Package for the call frame stack engine: operation, status and state codes,
// field widths and default sizes. No dependencies.
package cfse_pkg;

  // default sizes
  localparam int DEF_STACK_WORDS = 1024;
  localparam int DEF_MAX_FRAMES  = 64;
  localparam int DEF_MAX_ARGS    = 16;
  localparam int DEF_MAX_LOCALS  = 16;
  localparam int DEF_WORD_BITS   = 32;

  // fixed field widths
  localparam int OP_W     = 4;
  localparam int FID_W    = 16;
  localparam int CNT_W    = 5;
  localparam int SLOT_W   = 4;
  localparam int DATA_W   = 32;
  localparam int DEPTH_W  = 7;
  localparam int STAT_W   = 2;
  localparam int CUR_W    = 6;

  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [OP_W-1:0] {
    OP_CALL      = 4'd0,
    OP_FILL      = 4'd1,
    OP_RETURN    = 4'd2,
    OP_GET_LOCAL = 4'd3,
    OP_SET_LOCAL = 4'd4,
    OP_GET_ARG   = 4'd5,
    OP_SET_ARG   = 4'd6,
    OP_GET_BP    = 4'd7,
    OP_GET_RA    = 4'd8,
    OP_CURRENT   = 4'd9
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_FRAME = 2'd1,
    ST_RANGE    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALL_BP,
    S_READ,
    S_RETURN
  } state_t;

  typedef struct packed {
    logic [FID_W-1:0] fid;
    logic [CNT_W-1:0] argc;
    logic [CNT_W-1:0] locc;
  } frame_desc_t;

endpackage

// ----- hw/rtl/call_frame_stack_engine.sv -----
// Call frame stack engine: word store, frame descriptor store and base store,
// with the top frame's descriptor held in registers. Depends on cfse_pkg.
// Results pass the pending and output registers; call passes S_CALL_BP (RA and
// BP share the single word store port), return S_RETURN (frame store read) and
// get_* S_READ (word store read); a beat is taken only when no result is pending.
// Reset (rst_n, synchronous): stack empty, pipeline empty; the memories are
// not cleared and need no clearing pass.
module call_frame_stack_engine #(
  parameter int STACK_WORDS = cfse_pkg::DEF_STACK_WORDS,
  parameter int MAX_FRAMES  = cfse_pkg::DEF_MAX_FRAMES,
  parameter int MAX_ARGS    = cfse_pkg::DEF_MAX_ARGS,
  parameter int MAX_LOCALS  = cfse_pkg::DEF_MAX_LOCALS,
  parameter int WORD_BITS   = cfse_pkg::DEF_WORD_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // function_id, arg_count, local_count, return_addr, base_ptr, slot_index,
  // word_value (from bit 0 up), 2 zero pad bits
  input  logic [cfse_pkg::IN_TDATA_W-1:0]     in_tdata,
  // operation
  input  logic [cfse_pkg::OP_W-1:0]           in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // read_data, top_function_id, top_arg_count, top_local_count, frame_depth
  // (from bit 0 up), 7 zero pad bits
  output logic [cfse_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // status
  output logic [cfse_pkg::STAT_W-1:0]         out_tuser
);
  import cfse_pkg::*;

  localparam int AW  = $clog2(STACK_WORDS);
  localparam int TW  = AW + 1;
  localparam int SW  = AW + 2;
  localparam int FW  = $clog2(MAX_FRAMES);
  localparam int FCW = $clog2(MAX_FRAMES + 1);

  localparam logic [8:0]     MAX_ARGS_V   = 9'(MAX_ARGS);
  localparam logic [8:0]     MAX_LOCALS_V = 9'(MAX_LOCALS);
  localparam logic [FCW-1:0] MAX_FRAMES_V = FCW'(MAX_FRAMES);
  localparam logic [SW-1:0]  STACK_V      = SW'(STACK_WORDS);

  // input fields
  logic [FID_W-1:0]  in_fid;
  logic [CNT_W-1:0]  in_argc;
  logic [CNT_W-1:0]  in_locc;
  logic [DATA_W-1:0] in_ra;
  logic [DATA_W-1:0] in_bp;
  logic [SLOT_W-1:0] in_slot;
  logic [DATA_W-1:0] in_wv;
  op_t               in_op;

  assign in_fid  = in_tdata[15:0];
  assign in_argc = in_tdata[20:16];
  assign in_locc = in_tdata[25:21];
  assign in_ra   = in_tdata[57:26];
  assign in_bp   = in_tdata[89:58];
  assign in_slot = in_tdata[93:90];
  assign in_wv   = in_tdata[125:94];
  assign in_op   = op_t'(in_tuser);

  // control and top-of-stack registers
  state_t            state_r, state_nxt;
  logic [FCW-1:0]    frame_count_r, frame_count_nxt;
  logic [TW-1:0]     word_top_r, word_top_nxt;
  logic [CUR_W-1:0]  fill_cur_r, fill_cur_nxt;
  frame_desc_t       top_r, top_nxt;
  logic [AW-1:0]     top_base_r, top_base_nxt;
  logic [AW-1:0]     bp_addr_r, bp_addr_nxt;
  logic [WORD_BITS-1:0] bp_word_r, bp_word_nxt;

  // pending result and output register
  logic              pend_valid_r, pend_valid_nxt;
  logic [DATA_W-1:0] pend_rd_r, pend_rd_nxt;
  status_t           pend_st_r, pend_st_nxt;
  logic              pend_load;
  logic              out_move;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_rd_r;
  frame_desc_t       out_top_r;
  logic [DEPTH_W-1:0] out_depth_r;
  status_t           out_st_r;

  // memories
  logic [WORD_BITS-1:0] word_mem [STACK_WORDS];
  frame_desc_t          info_mem [MAX_FRAMES];
  logic [AW-1:0]        base_mem [MAX_FRAMES];

  logic                 wm_we, wm_re;
  logic [AW-1:0]        wm_addr;
  logic [WORD_BITS-1:0] wm_wdata;
  logic [WORD_BITS-1:0] wm_rdata_r;

  logic                 fm_we, fm_re;
  logic [FW-1:0]        fm_addr;
  frame_desc_t          info_rd_r;
  logic [AW-1:0]        base_rd_r;

  logic              accept;
  logic [DEPTH_W-1:0] frame_size;
  logic [CUR_W-1:0]  fill_total;
  logic [AW-1:0]     arg_top;     // base + arg count: RA slot
  logic [AW-1:0]     slot_a;
  logic [CUR_W-1:0]  ret_fill;

  assign in_tready  = (state_r == S_IDLE) && !pend_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign frame_size = DEPTH_W'(in_argc) + DEPTH_W'(in_locc) + DEPTH_W'(2);
  assign fill_total = CUR_W'(top_r.argc) + CUR_W'(top_r.locc);
  assign arg_top    = top_base_r + AW'(top_r.argc);
  assign slot_a     = AW'(in_slot);
  assign ret_fill   = CUR_W'(info_rd_r.argc) + CUR_W'(info_rd_r.locc);

  always_comb begin
    state_nxt       = state_r;
    frame_count_nxt = frame_count_r;
    word_top_nxt    = word_top_r;
    fill_cur_nxt    = fill_cur_r;
    top_nxt         = top_r;
    top_base_nxt    = top_base_r;
    bp_addr_nxt     = bp_addr_r;
    bp_word_nxt     = bp_word_r;
    pend_load       = 1'b0;
    pend_rd_nxt     = pend_rd_r;
    pend_st_nxt     = pend_st_r;
    wm_we           = 1'b0;
    wm_re           = 1'b0;
    wm_addr         = arg_top;
    wm_wdata        = WORD_BITS'(in_wv);
    fm_we           = 1'b0;
    fm_re           = 1'b0;
    fm_addr         = FW'(frame_count_r);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          pend_rd_nxt = '0;
          pend_st_nxt = ST_OK;
          if (in_op == OP_CALL) begin
            if ({4'd0, in_argc} > MAX_ARGS_V || {4'd0, in_locc} > MAX_LOCALS_V) begin
              pend_st_nxt = ST_RANGE;
              pend_load   = 1'b1;
            end else if (frame_count_r >= MAX_FRAMES_V ||
                         SW'(word_top_r) + SW'(frame_size) > STACK_V) begin
              pend_st_nxt = ST_OVERFLOW;
              pend_load   = 1'b1;
            end else begin
              fm_we           = 1'b1;
              fm_addr         = FW'(frame_count_r);
              wm_we           = 1'b1;
              wm_addr         = AW'(word_top_r) + AW'(in_argc);
              wm_wdata        = WORD_BITS'(in_ra);
              bp_addr_nxt     = AW'(word_top_r) + AW'(in_argc) + AW'(1);
              bp_word_nxt     = WORD_BITS'(in_bp);
              top_nxt.fid     = in_fid;
              top_nxt.argc    = in_argc;
              top_nxt.locc    = in_locc;
              top_base_nxt    = AW'(word_top_r);
              word_top_nxt    = word_top_r + TW'(frame_size);
              frame_count_nxt = frame_count_r + FCW'(1);
              fill_cur_nxt    = '0;
              state_nxt       = S_CALL_BP;
            end
          end else if (frame_count_r == '0) begin
            // no frame: only valid operation codes report it
            if (in_tuser <= OP_CURRENT) begin
              pend_st_nxt = ST_NO_FRAME;
            end
            pend_load = 1'b1;
          end else begin
            unique case (in_op)
              OP_FILL: begin
                pend_load = 1'b1;
                if (fill_cur_r >= fill_total) begin
                  pend_st_nxt = ST_RANGE;
                end else begin
                  wm_we = 1'b1;
                  if (fill_cur_r < CUR_W'(top_r.argc)) begin
                    wm_addr = arg_top - AW'(1) - AW'(fill_cur_r);
                  end else begin
                    wm_addr = arg_top + AW'(2) + AW'(fill_cur_r - CUR_W'(top_r.argc));
                  end
                  fill_cur_nxt = fill_cur_r + CUR_W'(1);
                end
              end
              OP_RETURN: begin
                // fetch the frame below; it becomes the top
                fm_re           = 1'b1;
                fm_addr         = FW'(frame_count_r - FCW'(2));
                word_top_nxt    = TW'(top_base_r);
                frame_count_nxt = frame_count_r - FCW'(1);
                state_nxt       = S_RETURN;
              end
              OP_GET_LOCAL, OP_SET_LOCAL: begin
                wm_addr = arg_top + AW'(2) + slot_a;
                if ({1'b0, in_slot} >= top_r.locc) begin
                  pend_st_nxt = ST_RANGE;
                  pend_load   = 1'b1;
                end else if (in_op == OP_GET_LOCAL) begin
                  wm_re     = 1'b1;
                  state_nxt = S_READ;
                end else begin
                  wm_we     = 1'b1;
                  pend_load = 1'b1;
                end
              end
              OP_GET_ARG, OP_SET_ARG: begin
                wm_addr = arg_top - AW'(1) - slot_a;
                if ({1'b0, in_slot} >= top_r.argc) begin
                  pend_st_nxt = ST_RANGE;
                  pend_load   = 1'b1;
                end else if (in_op == OP_GET_ARG) begin
                  wm_re     = 1'b1;
                  state_nxt = S_READ;
                end else begin
                  wm_we     = 1'b1;
                  pend_load = 1'b1;
                end
              end
              OP_GET_BP: begin
                wm_addr   = arg_top + AW'(1);
                wm_re     = 1'b1;
                state_nxt = S_READ;
              end
              OP_GET_RA: begin
                wm_addr   = arg_top;
                wm_re     = 1'b1;
                state_nxt = S_READ;
              end
              default: begin
                // current and unused codes: status only
                pend_load = 1'b1;
              end
            endcase
          end
        end
      end
      S_CALL_BP: begin
        wm_we     = 1'b1;
        wm_addr   = bp_addr_r;
        wm_wdata  = bp_word_r;
        pend_load = 1'b1;
        state_nxt = S_IDLE;
      end
      S_READ: begin
        pend_rd_nxt = DATA_W'(wm_rdata_r);
        pend_load   = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_RETURN: begin
        if (frame_count_r != '0) begin
          top_nxt      = info_rd_r;
          top_base_nxt = base_rd_r;
          fill_cur_nxt = ret_fill;
        end else begin
          top_nxt      = '0;
          top_base_nxt = '0;
          fill_cur_nxt = '0;
        end
        pend_load = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // pending beat moves on when the output register is free or being taken;
  // the top fields are stable then since no item is accepted meanwhile
  assign out_move       = pend_valid_r && (!out_valid_r || out_tready);
  assign pend_valid_nxt = pend_load || (pend_valid_r && !out_move);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      frame_count_r <= '0;
      word_top_r    <= '0;
      fill_cur_r    <= '0;
      top_r         <= '0;
      top_base_r    <= '0;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      frame_count_r <= frame_count_nxt;
      word_top_r    <= word_top_nxt;
      fill_cur_r    <= fill_cur_nxt;
      top_r         <= top_nxt;
      top_base_r    <= top_base_nxt;
      pend_valid_r  <= pend_valid_nxt;
      out_valid_r   <= out_move || (out_valid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    bp_addr_r <= bp_addr_nxt;
    bp_word_r <= bp_word_nxt;
    pend_rd_r <= pend_rd_nxt;
    pend_st_r <= pend_st_nxt;
    if (out_move) begin
      out_rd_r    <= pend_rd_r;
      out_st_r    <= pend_st_r;
      out_top_r   <= (frame_count_r != '0) ? top_r : '0;
      out_depth_r <= DEPTH_W'(frame_count_r);
    end
  end

  // word store: one port
  always_ff @(posedge clk) begin
    if (wm_we) begin
      word_mem[wm_addr] <= wm_wdata;
    end
    if (wm_re) begin
      wm_rdata_r <= word_mem[wm_addr];
    end
  end

  // frame descriptor and base stores: one port each, shared address
  always_ff @(posedge clk) begin
    if (fm_we) begin
      info_mem[fm_addr] <= top_nxt;
      base_mem[fm_addr] <= top_base_nxt;
    end
    if (fm_re) begin
      info_rd_r <= info_mem[fm_addr];
      base_rd_r <= base_mem[fm_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_depth_r, out_top_r.locc, out_top_r.argc,
                       out_top_r.fid, out_rd_r};
  assign out_tuser  = out_st_r;

endmodule

// ----- tb/cfse_stack_monitor.sv -----
// Watches both stream channels of the call frame stack engine, predicts every
// result beat from its own copy of the frame stack and compares field by field.
// Depends on cfse_pkg.
module cfse_stack_monitor
  import cfse_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [OP_W-1:0]        in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [STAT_W-1:0]      out_tuser,
  output int                     fail_count,
  output int                     outstanding
);

  localparam int STACK_WORDS = DEF_STACK_WORDS;
  localparam int MAX_FRAMES  = DEF_MAX_FRAMES;
  localparam int MAX_ARGS    = DEF_MAX_ARGS;
  localparam int MAX_LOCALS  = DEF_MAX_LOCALS;

  typedef struct {
    logic [DATA_W-1:0]  read_data;
    logic [FID_W-1:0]   top_fid;
    logic [CNT_W-1:0]   top_argc;
    logic [CNT_W-1:0]   top_locc;
    logic [DEPTH_W-1:0] depth;
    status_t            status;
  } frame_reply_t;

  logic [DATA_W-1:0] words [STACK_WORDS];
  frame_desc_t       descs [MAX_FRAMES];
  logic [10:0]       bases [MAX_FRAMES];
  logic [10:0]       word_top;
  logic [DEPTH_W-1:0] frame_count;
  logic [CUR_W-1:0]  fill_pos;

  frame_reply_t replies [$];
  int errs = 0;

  // Advances the stack copy by one input beat and returns the reply it causes.
  function automatic frame_reply_t apply_frame_op(input logic [OP_W-1:0] op,
                                                  input logic [IN_TDATA_W-1:0] d);
    logic [FID_W-1:0]  fid;
    logic [CNT_W-1:0]  ac;
    logic [CNT_W-1:0]  lc;
    logic [DATA_W-1:0] ra;
    logic [DATA_W-1:0] bp;
    logic [SLOT_W-1:0] n;
    logic [DATA_W-1:0] wv;
    int t, b, a, l, addr, size;
    frame_reply_t r;
    fid = d[15:0];
    ac  = d[20:16];
    lc  = d[25:21];
    ra  = d[57:26];
    bp  = d[89:58];
    n   = d[93:90];
    wv  = d[125:94];
    r.read_data = '0;
    r.status    = ST_OK;
    if (op == OP_CALL) begin
      size = int'(ac) + int'(lc) + 2;
      if (ac > MAX_ARGS || lc > MAX_LOCALS) begin
        r.status = ST_RANGE;
      end else if (frame_count >= MAX_FRAMES || int'(word_top) + size > STACK_WORDS) begin
        r.status = ST_OVERFLOW;
      end else begin
        descs[frame_count].fid  = fid;
        descs[frame_count].argc = ac;
        descs[frame_count].locc = lc;
        bases[frame_count] = word_top;
        words[int'(word_top) + int'(ac)]     = ra;
        words[int'(word_top) + int'(ac) + 1] = bp;
        word_top    = 11'(int'(word_top) + size);
        frame_count = frame_count + DEPTH_W'(1);
        fill_pos    = '0;
      end
    end else if (op <= OP_CURRENT) begin
      if (frame_count == 0) begin
        r.status = ST_NO_FRAME;
      end else begin
        t = int'(frame_count) - 1;
        b = int'(bases[t]);
        a = int'(descs[t].argc);
        l = int'(descs[t].locc);
        case (op)
          OP_FILL: begin
            if (int'(fill_pos) >= a + l) begin
              r.status = ST_RANGE;
            end else begin
              // arguments sit below RA in reverse order, locals above BP
              addr = (int'(fill_pos) < a) ? b + a - 1 - int'(fill_pos) : b + 2 + int'(fill_pos);
              words[addr] = wv;
              fill_pos = fill_pos + CUR_W'(1);
            end
          end
          OP_RETURN: begin
            word_top    = 11'(b);
            frame_count = DEPTH_W'(t);
            fill_pos    = CUR_W'((t > 0) ? int'(descs[t-1].argc) + int'(descs[t-1].locc) : 0);
          end
          OP_GET_LOCAL, OP_SET_LOCAL: begin
            if (int'(n) >= l) begin
              r.status = ST_RANGE;
            end else if (op == OP_GET_LOCAL) begin
              r.read_data = words[b + a + 2 + int'(n)];
            end else begin
              words[b + a + 2 + int'(n)] = wv;
            end
          end
          OP_GET_ARG, OP_SET_ARG: begin
            if (int'(n) >= a) begin
              r.status = ST_RANGE;
            end else if (op == OP_GET_ARG) begin
              r.read_data = words[b + a - 1 - int'(n)];
            end else begin
              words[b + a - 1 - int'(n)] = wv;
            end
          end
          OP_GET_BP: r.read_data = words[b + a + 1];
          OP_GET_RA: r.read_data = words[b + a];
          default: ;
        endcase
      end
    end
    if (frame_count > 0) begin
      r.top_fid  = descs[frame_count-1].fid;
      r.top_argc = descs[frame_count-1].argc;
      r.top_locc = descs[frame_count-1].locc;
    end else begin
      r.top_fid  = '0;
      r.top_argc = '0;
      r.top_locc = '0;
    end
    r.depth = frame_count;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    frame_reply_t want;
    if (!rst_n) begin
      word_top    = '0;
      frame_count = '0;
      fill_pos    = '0;
      replies.delete();
    end else begin
      // a reply never leaves on the edge its own beat enters, so compare first
      if (out_tvalid && out_tready) begin
        if (replies.size() == 0) begin
          $error("result beat with no input beat pending");
          errs++;
        end else begin
          want = replies.pop_front();
          if (out_tdata[31:0] !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, out_tdata[31:0]);
            errs++;
          end
          if (out_tdata[47:32] !== want.top_fid) begin
            $error("top_function_id: expected %h, got %h", want.top_fid, out_tdata[47:32]);
            errs++;
          end
          if (out_tdata[52:48] !== want.top_argc) begin
            $error("top_arg_count: expected %0d, got %0d", want.top_argc, out_tdata[52:48]);
            errs++;
          end
          if (out_tdata[57:53] !== want.top_locc) begin
            $error("top_local_count: expected %0d, got %0d", want.top_locc, out_tdata[57:53]);
            errs++;
          end
          if (out_tdata[64:58] !== want.depth) begin
            $error("frame_depth: expected %0d, got %0d", want.depth, out_tdata[64:58]);
            errs++;
          end
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready) replies.push_back(apply_frame_op(in_tuser, in_tdata));
    end
    fail_count  <= errs;
    outstanding <= replies.size();
  end

endmodule

// ----- tb/tb_call_frame_stack_engine.sv -----
// Top of the call frame stack engine bench: clock, reset, directed and random
// operation beats with random idling on both channels, and the verdict.
// Depends on cfse_pkg, call_frame_stack_engine and cfse_stack_monitor.
module tb_call_frame_stack_engine;
  import cfse_pkg::*;

  localparam int STACK_WORDS = DEF_STACK_WORDS;
  localparam int MAX_FRAMES  = DEF_MAX_FRAMES;
  localparam int MAX_ARGS    = DEF_MAX_ARGS;
  localparam int MAX_LOCALS  = DEF_MAX_LOCALS;
  localparam int RANDOM_OPS  = 1450;
  localparam int PHASE_LEN   = 160;
  localparam logic [OP_W-1:0] OP_UNUSED_TOP = 4'hF;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]        in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]      out_tuser;
  int                     fail_count;
  int                     outstanding;

  // stack shape as the stimulus sees it, used to keep reads on written words
  int sh_base [MAX_FRAMES];
  int sh_argc [MAX_FRAMES];
  int sh_locc [MAX_FRAMES];
  bit sh_written [STACK_WORDS];
  int sh_top = 0;
  int sh_depth = 0;
  int sh_cursor = 0;

  int mode = 0;
  bit calm = 1'b0;

  call_frame_stack_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  cfse_stack_monitor monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Updates the stack shape; returns 1 when the beat is not ignored.
  function automatic bit track_effect(input logic [OP_W-1:0] op, input int ac,
                                      input int lc, input int slot);
    int t, b, a, l;
    if (op == OP_CALL) begin
      if (ac > MAX_ARGS || lc > MAX_LOCALS || sh_depth >= MAX_FRAMES ||
          sh_top + ac + lc + 2 > STACK_WORDS) return 1'b0;
      sh_base[sh_depth] = sh_top;
      sh_argc[sh_depth] = ac;
      sh_locc[sh_depth] = lc;
      sh_written[sh_top + ac]     = 1'b1;
      sh_written[sh_top + ac + 1] = 1'b1;
      sh_top    = sh_top + ac + lc + 2;
      sh_depth  = sh_depth + 1;
      sh_cursor = 0;
      return 1'b1;
    end
    if (op > OP_CURRENT || sh_depth == 0) return 1'b0;
    t = sh_depth - 1;
    b = sh_base[t];
    a = sh_argc[t];
    l = sh_locc[t];
    case (op)
      OP_FILL: begin
        if (sh_cursor >= a + l) return 1'b0;
        sh_written[(sh_cursor < a) ? b + a - 1 - sh_cursor : b + 2 + sh_cursor] = 1'b1;
        sh_cursor++;
      end
      OP_RETURN: begin
        sh_top    = b;
        sh_depth  = t;
        sh_cursor = (t > 0) ? sh_argc[t-1] + sh_locc[t-1] : 0;
      end
      OP_GET_LOCAL, OP_SET_LOCAL: begin
        if (slot >= l) return 1'b0;
        if (op == OP_SET_LOCAL) sh_written[b + a + 2 + slot] = 1'b1;
      end
      OP_GET_ARG, OP_SET_ARG: begin
        if (slot >= a) return 1'b0;
        if (op == OP_SET_ARG) sh_written[b + a - 1 - slot] = 1'b1;
      end
      default: ;
    endcase
    return 1'b1;
  endfunction

  task automatic send_op(input logic [OP_W-1:0] op, input logic [FID_W-1:0] fid,
                         input logic [CNT_W-1:0] ac, input logic [CNT_W-1:0] lc,
                         input logic [DATA_W-1:0] ra, input logic [DATA_W-1:0] bp,
                         input logic [SLOT_W-1:0] slot, input logic [DATA_W-1:0] wv);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    void'(track_effect(op, int'(ac), int'(lc), int'(slot)));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, wv, slot, bp, ra, lc, ac, fid};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic random_op();
    logic [OP_W-1:0]   op;
    logic [CNT_W-1:0]  ac;
    logic [CNT_W-1:0]  lc;
    logic [SLOT_W-1:0] slot;
    int pick, call_w, ret_w, fill_pct, a, l, b, lo, hi;
    a = 0;
    l = 0;
    b = 0;
    if (sh_depth > 0) begin
      a = sh_argc[sh_depth-1];
      l = sh_locc[sh_depth-1];
      b = sh_base[sh_depth-1];
    end
    // 0 balanced, 1 deep chain of tiny frames, 2 unwinding, 3 wide frames
    case (mode)
      0:       begin call_w = 15; ret_w = 12; fill_pct = 90; end
      1:       begin call_w = 55; ret_w = 3;  fill_pct = 25; end
      2:       begin call_w = 5;  ret_w = 45; fill_pct = 90; end
      default: begin call_w = 50; ret_w = 4;  fill_pct = 25; end
    endcase
    pick = $urandom_range(0, 99);
    if (sh_depth > 0 && sh_cursor < a + l && $urandom_range(0, 99) < fill_pct) begin
      op = OP_FILL;
    end else if (pick < call_w) begin
      op = OP_CALL;
    end else if (pick < call_w + ret_w) begin
      op = OP_RETURN;
    end else begin
      pick = $urandom_range(0, 19);
      if (pick < 4 || pick == 17)       op = OP_GET_LOCAL;
      else if (pick < 6)                op = OP_SET_LOCAL;
      else if (pick < 10 || pick == 18) op = OP_GET_ARG;
      else if (pick < 12)               op = OP_SET_ARG;
      else if (pick == 12)              op = OP_GET_BP;
      else if (pick == 13)              op = OP_GET_RA;
      else if (pick == 15)              op = OP_FILL;
      else if (pick == 16)
        op = OP_W'($urandom_range(int'(OP_CURRENT) + 1, int'(OP_UNUSED_TOP)));
      else                              op = OP_CURRENT;
    end

    hi = (mode == 1) ? 1 : (mode == 3) ? MAX_ARGS : 3;
    lo = (mode == 3) ? 10 : 0;
    ac = CNT_W'($urandom_range(lo, hi));
    lc = CNT_W'($urandom_range(lo, hi));
    pick = $urandom_range(0, 19);
    if (pick >= 16) begin
      ac = CNT_W'($urandom_range(0, MAX_ARGS));
      lc = CNT_W'($urandom_range(0, MAX_LOCALS));
    end
    if (pick == 19) begin
      if ($urandom_range(0, 1)) ac = CNT_W'($urandom_range(MAX_ARGS + 1, 31));
      else                      lc = CNT_W'($urandom_range(MAX_LOCALS + 1, 31));
    end

    slot = SLOT_W'($urandom_range(0, 15));
    if ((op == OP_GET_LOCAL || op == OP_SET_LOCAL) && l > 0 && $urandom_range(0, 7) != 0)
      slot = SLOT_W'($urandom_range(0, l - 1));
    if ((op == OP_GET_ARG || op == OP_SET_ARG) && a > 0 && $urandom_range(0, 7) != 0)
      slot = SLOT_W'($urandom_range(0, a - 1));
    // a slot never written turns the read into a write
    if (op == OP_GET_LOCAL && int'(slot) < l && !sh_written[b + a + 2 + int'(slot)])
      op = OP_SET_LOCAL;
    if (op == OP_GET_ARG && int'(slot) < a && !sh_written[b + a - 1 - int'(slot)])
      op = OP_SET_ARG;

    send_op(op, FID_W'($urandom()), ac, lc, $urandom(), $urandom(), slot, $urandom());
  endtask

  // result side: out_tready may drop at random before each beat
  initial begin : sink
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int issued;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_CALL;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty stack, then oversize calls
    send_op(OP_FILL, 16'h0, 5'd0, 5'd0, 32'h0, 32'h0, 4'h0, 32'hFFFF_FFFF);
    send_op(OP_RETURN, 16'h0, 5'd0, 5'd0, 32'h0, 32'h0, 4'h0, 32'h0);
    send_op(OP_GET_BP, 16'h0, 5'd0, 5'd0, 32'h0, 32'h0, 4'h0, 32'h0);
    send_op(OP_UNUSED_TOP, 16'hFFFF, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF,
            32'hFFFF_FFFF);
    send_op(OP_CALL, 16'h1234, 5'd17, 5'd0, 32'h1, 32'h2, 4'h0, 32'h0);
    send_op(OP_CALL, 16'h0001, 5'd16, 5'd31, 32'h1, 32'h2, 4'h0, 32'h0);
    // frame with no slots: fill and slot access fall out of range
    send_op(OP_CALL, 16'h0000, 5'd0, 5'd0, 32'h8000_0000, 32'h7FFF_FFFF, 4'h0, 32'h0);
    send_op(OP_FILL, 16'h0, 5'd0, 5'd0, 32'h0, 32'h0, 4'h0, 32'h1234_5678);
    send_op(OP_GET_LOCAL, 16'h0, 5'd0, 5'd0, 32'h0, 32'h0, 4'h0, 32'h0);
    send_op(OP_GET_ARG, 16'h0, 5'd0, 5'd0, 32'h0, 32'h0, 4'hF, 32'h0);
    send_op(OP_GET_BP, 16'h0, 5'd0, 5'd0, 32'h0, 32'h0, 4'h0, 32'h0);
    send_op(OP_GET_RA, 16'h0, 5'd0, 5'd0, 32'h0, 32'h0, 4'h0, 32'h0);
    // nested frame, two args and one local, filled then one fill too many
    send_op(OP_CALL, 16'hFFFF, 5'd2, 5'd1, 32'hFFFF_FFFF, 32'h0000_0000, 4'hF, 32'h0);
    send_op(OP_FILL, 16'h0, 5'd0, 5'd0, 32'h0, 32'h0, 4'h0, 32'h8000_0000);
    send_op(OP_FILL, 16'h0, 5'd0, 5'd0, 32'h0, 32'h0, 4'h0, 32'h7FFF_FFFF);
    send_op(OP_FILL, 16'h0, 5'd0, 5'd0, 32'h0, 32'h0, 4'h0, 32'hFFFF_FFFF);
    send_op(OP_FILL, 16'h0, 5'd0, 5'd0, 32'h0, 32'h0, 4'h0, 32'h5555_AAAA);
    send_op(OP_GET_ARG, 16'h0, 5'd0, 5'd0, 32'h0, 32'h0, 4'h0, 32'h0);
    send_op(OP_SET_ARG, 16'h0, 5'd0, 5'd0, 32'h0, 32'h0, 4'h1, 32'hA5A5_5A5A);
    send_op(OP_GET_ARG, 16'h0, 5'd0, 5'd0, 32'h0, 32'h0, 4'h1, 32'h0);
    send_op(OP_SET_LOCAL, 16'h0, 5'd0, 5'd0, 32'h0, 32'h0, 4'h0, 32'h0000_0000);
    send_op(OP_GET_LOCAL, 16'h0, 5'd0, 5'd0, 32'h0, 32'h0, 4'h0, 32'h0);
    send_op(OP_CURRENT, 16'h0, 5'd0, 5'd0, 32'h0, 32'h0, 4'h0, 32'h0);
    // unwind to empty
    send_op(OP_RETURN, 16'h0, 5'd0, 5'd0, 32'h0, 32'h0, 4'h0, 32'h0);
    send_op(OP_FILL, 16'h0, 5'd0, 5'd0, 32'h0, 32'h0, 4'h0, 32'h1);
    send_op(OP_RETURN, 16'h0, 5'd0, 5'd0, 32'h0, 32'h0, 4'h0, 32'h0);
    send_op(OP_CURRENT, 16'h0, 5'd0, 5'd0, 32'h0, 32'h0, 4'h0, 32'h0);

    issued = 0;
    while (issued < RANDOM_OPS) begin
      if (issued % PHASE_LEN == 0) begin
        mode = $urandom_range(0, 3);
        calm = ($urandom_range(0, 3) == 0);
      end
      random_op();
      issued++;
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_call_frame_stack_engine: clean");
    end else begin
      $display("tb_call_frame_stack_engine: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #600000;
    $display("tb_call_frame_stack_engine: errors");
    $finish;
  end

endmodule
